// ===== sv/tdm_circuit_switch_forwarder_top_assert.svh =====
// Assertion macros for the circuit switch forwarder checker.
`ifndef TDM_CIRCUIT_SWITCH_FORWARDER_TOP_ASSERT_SVH
`define TDM_CIRCUIT_SWITCH_FORWARDER_TOP_ASSERT_SVH
`define CSF_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define CSF_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== sv/csf_pkg.sv =====
// Package: constants, codes and types of the circuit switch forwarder.
`timescale 1ns / 1ps
package csf_pkg;
  localparam int MAX_PORTS  = 16;
  localparam int MAX_SLICES = 16;
  localparam int PW = $clog2(MAX_PORTS);
  localparam int SW = $clog2(MAX_SLICES);
  localparam int SCHED_DEPTH = MAX_PORTS * MAX_SLICES;
  localparam int SAW = $clog2(SCHED_DEPTH);

  typedef enum logic [2:0] {
    OP_PACKET = 3'd0, OP_WR_SCHED = 3'd1, OP_WR_STATIC = 3'd2,
    OP_CLR_STATIC = 3'd3, OP_CLR_SCHED = 3'd4, OP_RD_PORT = 3'd5,
    OP_RSV6 = 3'd6, OP_RSV7 = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_FWD = 3'd0, ST_DROP_SW = 3'd1, ST_DROP_NC = 3'd2, ST_DROP_BP = 3'd3,
    ST_WR_OK = 3'd4, ST_WR_REJ = 3'd5, ST_DONE = 3'd6, ST_RSV = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    CFG_SCHED_EN = 3'd0, CFG_EPOCH = 3'd1, CFG_SLICE_TICKS = 3'd2,
    CFG_NUM_SLICES = 3'd3, CFG_SWITCH_TICKS = 3'd4, CFG_NUM_PORTS = 3'd5,
    CFG_RSV6 = 3'd6, CFG_RSV7 = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_LOOK, S_EVAL, S_CNT, S_OUT
  } state_t;
endpackage

// ===== sv/tdm_circuit_switch_forwarder_top.sv =====
// Top level: time-slotted circuit switch forwarding engine.
//
//  channel | dir | handshake                      | payload
//  s_axis  | in  | s_axis_tvalid / s_axis_tready  | tdata: operation, port, time, size, newp, sidx
//  m_axis  | out | m_axis_tvalid / m_axis_tready  | tdata: status, port, slice, 7 counters
//  cfg     | in  | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// One item at a time. A packet in schedule mode at or past the epoch runs a radix-2
// restoring divider, one quotient bit a cycle over the 63-bit elapsed time,
// then lookup, evaluate and count; the next item is taken only once the result
// has been accepted. Other items pass through without the divider steps.
// The per-port counters live in two synchronous memories, packets and bytes
// (read, add, write back); the schedule table in another. Valid bits are
// flip-flops cleared by reset. A stalled result holds in the output register;
// s_axis_tready is low until it is taken.
`timescale 1ns / 1ps
module tdm_circuit_switch_forwarder_top import csf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] operation, [6:3] in_port, [69:7] arrival_time, [85:70] packet_size,
  // [89:86] new_out_port, [93:90] slice_index, [95:94] zero
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] status, [6:3] out_port, [10:7] slice, [74:11] total_packets,
  // [138:75] total_bytes, [202:139] drops_switching, [266:203] drops_no_circuit,
  // [330:267] drops_bad_port, [394:331] port_packets, [458:395] port_bytes,
  // [463:459] zero
  output logic [463:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  // configuration
  logic        sched_en;
  logic [62:0] epoch;
  logic [31:0] slice_ticks, switch_ticks;
  logic [4:0]  slice_count, num_ports;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_en <= 1'b0; epoch <= '0; slice_ticks <= 32'd1;
      slice_count <= 5'd1; switch_ticks <= '0; num_ports <= 5'd16;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCHED_EN:     sched_en <= cfg_data[0];
        CFG_EPOCH:        epoch <= cfg_data[62:0];
        CFG_SLICE_TICKS:  slice_ticks <= cfg_data[31:0];
        CFG_NUM_SLICES:   slice_count <= cfg_data[4:0];
        CFG_SWITCH_TICKS: switch_ticks <= cfg_data[31:0];
        CFG_NUM_PORTS:    num_ports <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [4:0] eff_slices, eff_ports;
  assign eff_slices = (slice_count > 5'(MAX_SLICES)) ? 5'(MAX_SLICES) : slice_count;
  assign eff_ports  = (num_ports > 5'(MAX_PORTS)) ? 5'(MAX_PORTS) : num_ports;

  // latched item
  op_t         op;
  logic [3:0]  port, newp, sidx;
  logic [62:0] now;
  logic [15:0] size;

  state_t state, state_next;
  logic [6:0]  cnt;
  logic [62:0] quo;   // dividend shifts out, quotient shifts in
  logic [32:0] rem;
  logic        do_div;

  // slice from quotient mod slices: quotient is < 2^63, reduce by
  // repeated subtract of shifted slice count is heavy; instead keep a running
  // residue of the quotient mod eff_slices as bits shift in.
  logic [4:0]  qmod, qmod_dbl;
  logic [3:0]  cur;
  logic        guard;

  // state machine; the divider takes one step per dividend bit, 63 in all
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_DIV;
      S_DIV:  if (!do_div || cnt == 7'd62) state_next = S_LOOK;
      S_LOOK: state_next = S_EVAL;
      S_EVAL: state_next = S_CNT;
      S_CNT:  state_next = S_OUT;
      S_OUT:  if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    m_axis_tvalid = (state == S_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // residue step: qmod = (2*qmod + bit) mod eff_slices, qmod < eff_slices
  logic [5:0] qm2;
  logic [32:0] rem_sh;
  logic        qbit;
  always_comb begin
    rem_sh = {rem[31:0], quo[62]};
    qbit   = (rem_sh >= {1'b0, slice_ticks});
    qm2    = {qmod, qbit};
    if (qm2 >= {1'b0, eff_slices}) qmod_dbl = 5'(qm2 - {1'b0, eff_slices});
    else qmod_dbl = qm2[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; do_div <= 1'b0;
    end else if (state == S_IDLE && s_axis_tvalid) begin
      op   <= op_t'(s_axis_tdata[2:0]);
      port <= s_axis_tdata[6:3];
      now  <= s_axis_tdata[69:7];
      size <= s_axis_tdata[85:70];
      newp <= s_axis_tdata[89:86];
      sidx <= s_axis_tdata[93:90];
      do_div <= (op_t'(s_axis_tdata[2:0]) == OP_PACKET) && sched_en
        && (s_axis_tdata[69:7] >= epoch) && (slice_ticks != 0);
      quo  <= s_axis_tdata[69:7] - epoch;
      rem  <= '0;
      qmod <= '0;
      cnt  <= '0;
    end else if (state == S_DIV && do_div) begin
      rem  <= qbit ? rem_sh - {1'b0, slice_ticks} : rem_sh;
      quo  <= {quo[61:0], qbit};
      qmod <= (eff_slices == 0) ? 5'd0 : qmod_dbl;
      cnt  <= cnt + 7'd1;
    end
  end

  always_comb begin
    cur   = (do_div && eff_slices != 0) ? qmod[3:0] : 4'd0;
    guard = 1'b0;
    if (do_div && switch_ticks != 0) begin
      if (switch_ticks >= slice_ticks) guard = 1'b1;
      else guard = rem[31:0] >= (slice_ticks - switch_ticks);
    end
  end

  // tables
  logic [PW-1:0] sched_mem [SCHED_DEPTH];
  logic [SCHED_DEPTH-1:0] sched_vld;
  logic [PW-1:0] stat_out [MAX_PORTS];
  logic [MAX_PORTS-1:0] stat_vld;
  logic [PW-1:0] sched_rd;
  logic [SAW-1:0] lk_addr, wr_addr;
  logic wr_rej;
  logic sched_wr_ok;

  assign lk_addr = {cur, port};
  assign wr_addr = {sidx, port};
  assign wr_rej = (port == newp) || ({1'b0, port} >= eff_ports)
    || ({1'b0, newp} >= eff_ports);
  assign sched_wr_ok = !wr_rej && sched_en && ({1'b0, sidx} < eff_slices);

  // port counter memories
  logic [63:0] pp_mem [MAX_PORTS];
  logic [63:0] pb_mem [MAX_PORTS];
  logic [63:0] pp_rd, pb_rd;
  logic [MAX_PORTS-1:0] pc_vld;  // zero until first written
  logic [PW-1:0] pc_addr;
  logic found;
  logic [PW-1:0] o;

  always_ff @(posedge clk) begin
    if (state == S_LOOK) sched_rd <= sched_mem[lk_addr];
    if (state == S_EVAL && op == OP_WR_SCHED && sched_wr_ok)
      sched_mem[wr_addr] <= newp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_vld <= '0; stat_vld <= '0;
    end else if (state == S_EVAL) begin
      case (op)
        OP_WR_SCHED: if (sched_wr_ok)
          sched_vld[wr_addr] <= 1'b1;
        OP_WR_STATIC: if (!wr_rej) begin
          stat_vld[port] <= 1'b1;
          stat_out[port] <= newp;
        end
        OP_CLR_STATIC: stat_vld <= '0;
        OP_CLR_SCHED:  sched_vld <= '0;
        default: ;
      endcase
    end
  end

  // result registers
  status_t     r_status;
  logic [3:0]  r_out, r_cur;
  logic [63:0] tot_pk, tot_by, d_sw, d_nc, d_bp, r_ppk, r_pby;
  logic        upd;
  status_t     status_next;
  logic [3:0]  out_next;
  logic        upd_next;

  always_comb begin
    found = sched_en ? sched_vld[lk_addr] : stat_vld[port];
    o     = sched_en ? sched_rd : stat_out[port];
  end

  // outcome of the item, settled during S_EVAL
  always_comb begin
    status_next = ST_DONE;
    out_next    = '0;
    upd_next    = 1'b0;
    case (op)
      OP_PACKET: begin
        if (guard) status_next = ST_DROP_SW;
        else if (!found) status_next = ST_DROP_NC;
        else if ({1'b0, o} >= eff_ports) status_next = ST_DROP_BP;
        else begin
          status_next = ST_FWD; out_next = o; upd_next = 1'b1;
        end
      end
      OP_WR_SCHED:  status_next = sched_wr_ok ? ST_WR_OK : ST_WR_REJ;
      OP_WR_STATIC: status_next = wr_rej ? ST_WR_REJ : ST_WR_OK;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      pc_addr <= (op == OP_PACKET) ? o : port;
      pp_rd   <= pp_mem[(op == OP_PACKET) ? o : port];
      pb_rd   <= pb_mem[(op == OP_PACKET) ? o : port];
    end
    if (state == S_CNT && upd) begin
      pp_mem[pc_addr] <= (pc_vld[pc_addr] ? pp_rd : 64'd0) + 64'd1;
      pb_mem[pc_addr] <= (pc_vld[pc_addr] ? pb_rd : 64'd0) + 64'(size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tot_pk <= '0; tot_by <= '0; d_sw <= '0; d_nc <= '0; d_bp <= '0;
      pc_vld <= '0; upd <= 1'b0;
    end else begin
      if (state == S_EVAL) begin
        upd      <= upd_next;
        r_out    <= out_next;
        r_cur    <= (op == OP_PACKET) ? cur : 4'd0;
        r_status <= status_next;
        if (status_next == ST_DROP_SW) d_sw <= d_sw + 64'd1;
        if (status_next == ST_DROP_NC) d_nc <= d_nc + 64'd1;
        if (status_next == ST_DROP_BP) d_bp <= d_bp + 64'd1;
        if (upd_next) begin
          tot_pk <= tot_pk + 64'd1; tot_by <= tot_by + 64'(size);
        end
      end
      if (state == S_CNT) begin
        if (upd) pc_vld[pc_addr] <= 1'b1;
        if (op == OP_RD_PORT && pc_vld[pc_addr]) begin
          r_ppk <= pp_rd; r_pby <= pb_rd;
        end else begin
          r_ppk <= '0; r_pby <= '0;
        end
      end
    end
  end

  assign m_axis_tdata = {5'd0, r_pby, r_ppk, d_bp, d_nc, d_sw, tot_by, tot_pk,
                         r_cur, r_out, r_status};
endmodule

// ===== sv/csf_checker.sv =====
// Port-level checker for the forwarder, bound to the top level.
`timescale 1ns / 1ps
`include "tdm_circuit_switch_forwarder_top_assert.svh"
module csf_checker import csf_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [463:0] m_axis_tdata
);
  `CSF_ASSERT_IMPL(a_one_side, m_axis_tvalid, !s_axis_tready)
  `CSF_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `CSF_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CSF_ASSERT_IMPL(a_status, m_axis_tvalid, m_axis_tdata[2:0] != 3'd7)
endmodule

bind tdm_circuit_switch_forwarder_top csf_checker u_csf_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
